// ===== rtl/sqlspl_pkg.sv =====
// Package for the SQL statement splitter: item types, mode and kind codes,
// character constants and the control and status bundles of the core.
// No dependencies; every other file in rtl imports it.
package sqlspl_pkg;

  // Depth of the held-back whitespace run and the derived widths.
  localparam int SPACE_DEPTH = 16;
  localparam int SPACE_CNT_W = $clog2(SPACE_DEPTH + 1);
  localparam int SPACE_IDX_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  // One item can expand into at most this many actions.
  localparam int OPS_MAX = 5;
  localparam int OPS_CNT_W = $clog2(OPS_MAX + 1);

  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_SEMI  = 16'h003B;
  localparam logic [15:0] CH_BTICK = 16'h0060;
  localparam logic [15:0] CH_BSL   = 16'h005C;
  localparam logic [15:0] CH_SQ    = 16'h0027;
  localparam logic [15:0] CH_DQ    = 16'h0022;
  localparam logic [15:0] CH_STAR  = 16'h002A;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_NL    = 16'h000A;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SQ     = 3'd1,
    MODE_DQ     = 3'd2,
    MODE_BQ     = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_BLOCK  = 3'd5
  } mode_t;

  // Action kinds share their codes with the result kinds.
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EMIT_NONE  = 2'd0,
    EMIT_SPACE = 2'd1,
    EMIT_HEAD  = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic        end_of_script;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic [1:0]  out_kind;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] ch;
  } op_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] h0;
    logic [15:0] h1;
    logic [1:0]  hcnt;
    logic        esc;
    logic        dlm;
  } parse_t;

  typedef struct packed {
    parse_t                    next;
    op_t [OPS_MAX-1:0]         ops;
    logic [OPS_CNT_W-1:0]      n;
  } plan_t;

  typedef struct packed {
    logic      load;
    logic      advance;
    emit_sel_t emit;
    logic      last;
    logic      space_push;
    logic      space_step;
    logic      space_clr;
    logic      open_set;
    logic      open_clr;
  } cmd_t;

  typedef struct packed {
    logic  plan_empty;
    kind_t head_kind;
    logic  head_ws;
    logic  head_is_last;
    logic  spaces_left;
    logic  space_room;
    logic  stmt_open;
    logic  later_hard;
    logic  later_endst;
    logic  out_free;
  } status_t;

endpackage

// ===== rtl/sqlspl_ctrl.sv =====
// Controller of the SQL statement splitter: walks the action list of one
// item, flushing held whitespace and emitting results. Uses sqlspl_pkg.
module sqlspl_ctrl
  import sqlspl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!st.plan_empty) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        unique case (st.head_kind)
          KIND_CHAR: begin
            if (st.head_ws) begin
              cmd.space_push = st.stmt_open && st.space_room;
              cmd.advance    = 1'b1;
            end else if (st.spaces_left) begin
              if (st.out_free) begin
                cmd.emit       = EMIT_SPACE;
                cmd.space_step = 1'b1;
              end
            end else if (st.out_free) begin
              // The statement is open after this character.
              cmd.emit      = EMIT_HEAD;
              cmd.last      = !(st.later_hard || st.later_endst);
              cmd.open_set  = 1'b1;
              cmd.space_clr = 1'b1;
              cmd.advance   = 1'b1;
            end
          end
          KIND_END: begin
            if (!st.stmt_open) begin
              cmd.space_clr = 1'b1;
              cmd.advance   = 1'b1;
            end else if (st.out_free) begin
              cmd.emit      = EMIT_HEAD;
              cmd.last      = !st.later_hard;
              cmd.open_clr  = 1'b1;
              cmd.space_clr = 1'b1;
              cmd.advance   = 1'b1;
            end
          end
          default: begin
            if (st.out_free) begin
              cmd.emit      = EMIT_HEAD;
              cmd.last      = 1'b1;
              cmd.open_clr  = 1'b1;
              cmd.space_clr = 1'b1;
              cmd.advance   = 1'b1;
            end
          end
        endcase
        if (cmd.advance && st.head_is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sqlspl_dp.sv =====
// Datapath of the SQL statement splitter: parse state, action list,
// whitespace buffer and output register. Uses sqlspl_pkg.
module sqlspl_dp
  import sqlspl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   st,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  function automatic logic is_ws(logic [15:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic op_t mk_op(kind_t k, logic [15:0] c);
    op_t o;
    o.kind = k;
    o.ch   = (k == KIND_CHAR) ? c : 16'h0000;
    return o;
  endfunction

  // Turns one character into the ordered list of actions it causes and the
  // parse state it leaves behind.
  function automatic plan_t make_plan(parse_t s, in_item_t it);
    plan_t                r;
    parse_t               p;
    op_t [OPS_MAX-1:0]    ops;
    logic [OPS_CNT_W-1:0] n;
    logic [15:0]          c;
    logic [15:0]          d;
    logic [15:0]          first;
    logic                 run_n;
    logic                 done;
    logic                 closed;
    logic                 ok;
    p      = s;
    ops    = '0;
    n      = '0;
    c      = it.char_code;
    run_n  = 1'b0;
    done   = 1'b0;
    closed = 1'b0;
    ok     = 1'b1;
    first  = 16'h0000;
    d      = (s.mode == MODE_SQ) ? CH_SQ : (s.mode == MODE_DQ) ? CH_DQ : CH_BTICK;

    unique case (s.mode)
      MODE_LINE: begin
        if (c == CH_NL) begin
          ops[n] = mk_op(KIND_CHAR, CH_NL);
          n      = n + 1'b1;
          p.mode = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (p.hcnt != 2'd0) begin
          p.hcnt = 2'd0;
          if (c == CH_SLASH) begin
            ops[n] = mk_op(KIND_CHAR, CH_SPACE);
            n      = n + 1'b1;
            p.mode = MODE_NORMAL;
            closed = 1'b1;
          end
        end
        if (!closed && (c == CH_STAR)) begin
          p.h0   = CH_STAR;
          p.hcnt = 2'd1;
        end
      end
      MODE_SQ, MODE_DQ, MODE_BQ: begin
        if (p.esc) begin
          p.esc  = 1'b0;
          ops[n] = mk_op(KIND_CHAR, c);
          n      = n + 1'b1;
        end else if (p.dlm) begin
          p.dlm = 1'b0;
          if (c == d) begin
            ops[n] = mk_op(KIND_CHAR, c);
            n      = n + 1'b1;
          end else begin
            p.mode = MODE_NORMAL;
            run_n  = 1'b1;
          end
        end else begin
          ops[n] = mk_op(KIND_CHAR, c);
          n      = n + 1'b1;
          if (c == CH_BSL) begin
            p.esc = 1'b1;
          end else if (c == d) begin
            p.dlm = 1'b1;
          end
        end
      end
      default: begin
        p.mode = MODE_NORMAL;
        run_n  = 1'b1;
      end
    endcase

    if (run_n) begin
      // Held "--" resolves first, then a held single '-' or '/'.
      if (p.hcnt == 2'd2) begin
        if (is_ws(c)) begin
          p.hcnt = 2'd0;
          p.mode = MODE_LINE;
          if (c == CH_NL) begin
            ops[n] = mk_op(KIND_CHAR, CH_NL);
            n      = n + 1'b1;
            p.mode = MODE_NORMAL;
          end
          done = 1'b1;
        end else begin
          ops[n] = mk_op(KIND_CHAR, p.h0);
          n      = n + 1'b1;
          p.h0   = p.h1;
          p.hcnt = 2'd1;
        end
      end
      if (!done && (p.hcnt == 2'd1)) begin
        first  = p.h0;
        p.hcnt = 2'd0;
        if ((first == CH_DASH) && (c == CH_DASH)) begin
          p.h1   = CH_DASH;
          p.hcnt = 2'd2;
          done   = 1'b1;
        end else if ((first == CH_SLASH) && (c == CH_STAR)) begin
          p.mode = MODE_BLOCK;
          done   = 1'b1;
        end else begin
          ops[n] = mk_op(KIND_CHAR, first);
          n      = n + 1'b1;
        end
      end
      if (!done) begin
        if ((c == CH_DASH) || (c == CH_SLASH)) begin
          p.h0   = c;
          p.hcnt = 2'd1;
        end else if (c == CH_HASH) begin
          p.mode = MODE_LINE;
        end else if ((c == CH_SQ) || (c == CH_DQ) || (c == CH_BTICK)) begin
          ops[n] = mk_op(KIND_CHAR, c);
          n      = n + 1'b1;
          p.mode = (c == CH_SQ) ? MODE_SQ : (c == CH_DQ) ? MODE_DQ : MODE_BQ;
        end else if (c == CH_SEMI) begin
          ops[n] = mk_op(KIND_END, c);
          n      = n + 1'b1;
        end else begin
          ops[n] = mk_op(KIND_CHAR, c);
          n      = n + 1'b1;
        end
      end
    end

    if (it.end_of_script) begin
      if (p.mode == MODE_BLOCK) begin
        ok = 1'b0;
      end else if ((p.mode == MODE_SQ) || (p.mode == MODE_DQ) || (p.mode == MODE_BQ)) begin
        ok = p.dlm && !p.esc;
      end else if (p.mode != MODE_LINE) begin
        if (p.hcnt == 2'd1) begin
          ops[n] = mk_op(KIND_CHAR, p.h0);
          n      = n + 1'b1;
        end
      end
      if (ok) begin
        ops[n] = mk_op(KIND_END, c);
        n      = n + 1'b1;
        ops[n] = mk_op(KIND_DONE, c);
        n      = n + 1'b1;
      end else begin
        ops[n] = mk_op(KIND_ERR, c);
        n      = n + 1'b1;
      end
      p = '0;
    end

    r.next = p;
    r.ops  = ops;
    r.n    = n;
    return r;
  endfunction

  parse_t                 parse;
  plan_t                  pl;
  op_t [OPS_MAX-1:0]      ops;
  logic [OPS_CNT_W-1:0]   n;
  logic [OPS_CNT_W-1:0]   head;
  op_t                    head_op;
  logic                   stmt_open;
  logic [15:0]            space_buf [SPACE_DEPTH];
  logic [SPACE_CNT_W-1:0] space_count;
  logic [SPACE_CNT_W-1:0] space_rd;
  logic                   later_hard;
  logic                   later_endst;

  assign pl      = make_plan(parse, in_item);
  assign head_op = ops[head];

  always_comb begin
    later_hard  = 1'b0;
    later_endst = 1'b0;
    for (int j = 0; j < OPS_MAX; j++) begin
      if ((OPS_CNT_W'(j) > head) && (OPS_CNT_W'(j) < n)) begin
        if (ops[j].kind == KIND_END) begin
          later_endst = 1'b1;
        end else if ((ops[j].kind != KIND_CHAR) || !is_ws(ops[j].ch)) begin
          later_hard = 1'b1;
        end
      end
    end
  end

  always_comb begin
    st.plan_empty   = (pl.n == '0);
    st.head_kind    = head_op.kind;
    st.head_ws      = is_ws(head_op.ch);
    st.head_is_last = (head == (n - 1'b1));
    st.spaces_left  = (space_rd < space_count);
    st.space_room   = (space_count < SPACE_CNT_W'(SPACE_DEPTH));
    st.stmt_open    = stmt_open;
    st.later_hard   = later_hard;
    st.later_endst  = later_endst;
    st.out_free     = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse       <= '0;
      n           <= '0;
      head        <= '0;
      stmt_open   <= 1'b0;
      space_count <= '0;
      space_rd    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        parse <= pl.next;
        n     <= pl.n;
        head  <= '0;
      end
      if (cmd.advance) begin
        head <= head + 1'b1;
      end
      if (cmd.space_push) begin
        space_count <= space_count + 1'b1;
      end
      if (cmd.space_step) begin
        space_rd <= space_rd + 1'b1;
      end
      if (cmd.space_clr) begin
        space_count <= '0;
        space_rd    <= '0;
      end
      if (cmd.open_set) begin
        stmt_open <= 1'b1;
      end
      if (cmd.open_clr) begin
        stmt_open <= 1'b0;
      end
      if (cmd.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ops <= pl.ops;
    end
    if (cmd.space_push) begin
      space_buf[space_count[SPACE_IDX_W-1:0]] <= head_op.ch;
    end
    if (cmd.emit == EMIT_SPACE) begin
      out_item.out_char    <= space_buf[space_rd[SPACE_IDX_W-1:0]];
      out_item.out_kind    <= KIND_CHAR;
      out_item.last_of_run <= 1'b0;
    end else if (cmd.emit == EMIT_HEAD) begin
      out_item.out_char    <= head_op.ch;
      out_item.out_kind    <= head_op.kind;
      out_item.last_of_run <= cmd.last;
    end
  end

endmodule

// ===== rtl/sql_statement_splitter_top.sv =====
// SQL statement splitter, top level. An accepted item causes zero to five
// actions. The input stalls until the controller has walked them all and
// flushed any held whitespace before them, and longer while out_stall is
// high. Results are registered in the output register.
// Reset (rst, synchronous): parser returns to normal mode, no statement open.
module sql_statement_splitter_top
  import sqlspl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // The datapath turns each accepted item into a short list of actions:
  // emit a character, close a statement, report the end of the script or an error.
  // The controller walks that list one action per cycle unless out_stall
  // holds it. Whitespace is held in a buffer and only flushed, one character
  // per cycle, once a non-whitespace character proves it lies inside a
  // statement; this flush and out_stall stretch an item beyond its actions.
  cmd_t    cmd;
  status_t st;

  sqlspl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The output register lets the next item be accepted while the last result
  // of the previous one still waits to be taken.
  sqlspl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
